FILE: hw/rtl/assert_macros.svh
// Assertion helpers included by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ipv4p_pkg.sv
package ipv4p_pkg;

   localparam int CHAR_W     = 8;
   localparam int OCTET_W    = 9;
   localparam int DONE_W     = 24;
   localparam int PORT_ACC_W = 17;
   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;
   localparam int KIND_W     = 3;

   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [OCTET_W-1:0]    OCTET_MAX = 9'd255;
   localparam logic [OCTET_W-1:0]    OCTET_SAT = 9'd256;
   localparam logic [PORT_ACC_W-1:0] PORT_MAX  = 17'd65535;
   localparam logic [PORT_ACC_W-1:0] PORT_SAT  = 17'd65536;

   typedef enum logic [6:0] {
      PH_OCT0 = 7'b0000001,
      PH_OCT1 = 7'b0000010,
      PH_OCT2 = 7'b0000100,
      PH_OCT3 = 7'b0001000,
      PH_PORT = 7'b0010000,
      PH_TAIL = 7'b0100000,
      PH_FAIL = 7'b1000000
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      ERR_NONE  = 3'd0,
      ERR_DELIM = 3'd1,
      ERR_CHAR  = 3'd2,
      ERR_RANGE = 3'd3,
      ERR_PORT  = 3'd4
   } err_kind_type;

   typedef struct packed {
      phase_type               phase;
      logic [OCTET_W-1:0]      octet_acc;
      logic [DONE_W-1:0]       octets_done;
      logic [PORT_ACC_W-1:0]   port_acc;
      logic                    port_seen;
      err_kind_type            err;
   } parse_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [PORT_W-1:0] port;
      err_kind_type      kind;
   } result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:       PH_OCT0,
      octet_acc:   '0,
      octets_done: '0,
      port_acc:    '0,
      port_seen:   1'b0,
      err:         ERR_NONE
   };

endpackage

FILE: hw/rtl/ipv4p_step.sv
module ipv4p_step (
   input  ipv4p_pkg::parse_state_type cur,
   input  logic [7:0]                 char_code,
   input  logic                       last_char,
   output ipv4p_pkg::parse_state_type nxt,
   output ipv4p_pkg::result_type      res
);
   import ipv4p_pkg::*;

   localparam int OCT_SUM_W  = OCTET_W + 3;
   localparam int PORT_SUM_W = PORT_ACC_W + 3;

   logic                    is_digit;
   logic                    is_dot;
   logic                    is_colon;
   logic [3:0]              digit;
   logic [OCT_SUM_W-1:0]    oct_sum;
   logic [OCTET_W-1:0]      oct_next;
   logic [PORT_SUM_W-1:0]   port_sum;
   logic [PORT_ACC_W-1:0]   port_next;
   err_kind_type            chk_cur;
   err_kind_type            chk_end;
   parse_state_type         upd;
   err_kind_type            kind;
   logic [PORT_W-1:0]       port_val;

   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign is_dot   = (char_code == CHAR_DOT);
   assign is_colon = (char_code == CHAR_COLON);
   assign digit    = 4'(char_code - CHAR_ZERO);

   // Decimal accumulate: x*10 + d as two shifts and two adds, then saturate.
   assign oct_sum  = ({3'b000, cur.octet_acc} << 3) + ({3'b000, cur.octet_acc} << 1)
                   + {{(OCT_SUM_W-4){1'b0}}, digit};
   assign oct_next = (oct_sum > {3'b000, OCTET_SAT}) ? OCTET_SAT : oct_sum[OCTET_W-1:0];

   assign port_sum  = ({3'b000, cur.port_acc} << 3) + ({3'b000, cur.port_acc} << 1)
                    + {{(PORT_SUM_W-4){1'b0}}, digit};
   assign port_next = (port_sum > {3'b000, PORT_SAT}) ? PORT_SAT
                                                       : port_sum[PORT_ACC_W-1:0];

   // A bad character outranks an out-of-range value.
   always_comb begin
      if (cur.err == ERR_CHAR) begin
         chk_cur = ERR_CHAR;
      end else if (cur.octet_acc > OCTET_MAX) begin
         chk_cur = ERR_RANGE;
      end else begin
         chk_cur = ERR_NONE;
      end
   end

   always_comb begin
      upd = cur;
      case (cur.phase)
         PH_OCT0, PH_OCT1, PH_OCT2: begin
            if (is_dot) begin
               if (chk_cur != ERR_NONE) begin
                  upd.phase = PH_FAIL;
                  upd.err   = chk_cur;
               end else begin
                  upd.octets_done = {cur.octets_done[DONE_W-9:0], cur.octet_acc[7:0]};
                  upd.octet_acc   = '0;
                  upd.err         = ERR_NONE;
                  case (cur.phase)
                     PH_OCT0: upd.phase = PH_OCT1;
                     PH_OCT1: upd.phase = PH_OCT2;
                     default: upd.phase = PH_OCT3;
                  endcase
               end
            end else if (is_colon) begin
               upd.phase = PH_FAIL;
               upd.err   = ERR_DELIM;
            end else if (is_digit) begin
               upd.octet_acc = oct_next;
            end else begin
               upd.err = ERR_CHAR;
            end
         end
         PH_OCT3: begin
            if (is_dot || is_colon) begin
               if (chk_cur != ERR_NONE) begin
                  upd.phase = PH_FAIL;
                  upd.err   = chk_cur;
               end else begin
                  upd.phase = is_colon ? PH_PORT : PH_TAIL;
               end
            end else if (is_digit) begin
               upd.octet_acc = oct_next;
            end else begin
               upd.err = ERR_CHAR;
            end
         end
         PH_PORT: begin
            if (is_digit) begin
               upd.port_acc  = port_next;
               upd.port_seen = 1'b1;
            end else begin
               upd.phase = PH_FAIL;
               upd.err   = ERR_PORT;
            end
         end
         default: begin
            upd = cur;
         end
      endcase
   end

   // End-of-text check on the fourth octet uses the updated state.
   always_comb begin
      if (upd.err == ERR_CHAR) begin
         chk_end = ERR_CHAR;
      end else if (upd.octet_acc > OCTET_MAX) begin
         chk_end = ERR_RANGE;
      end else begin
         chk_end = ERR_NONE;
      end
   end

   always_comb begin
      kind     = ERR_NONE;
      port_val = '0;
      case (upd.phase)
         PH_OCT0, PH_OCT1, PH_OCT2: kind = ERR_DELIM;
         PH_OCT3: kind = chk_end;
         PH_PORT: begin
            if (!upd.port_seen || (upd.port_acc > PORT_MAX)) begin
               kind = ERR_PORT;
            end else begin
               port_val = upd.port_acc[PORT_W-1:0];
            end
         end
         PH_TAIL: kind = ERR_NONE;
         default: kind = upd.err;
      endcase
   end

   always_comb begin
      res.kind = kind;
      if (kind == ERR_NONE) begin
         res.address = {upd.octets_done, upd.octet_acc[7:0]};
         res.port    = port_val;
      end else begin
         res.address = '0;
         res.port    = '0;
      end
      nxt = last_char ? STATE_RESET : upd;
   end

endmodule

FILE: hw/rtl/ipv4_text_address_parser_core.sv
// A final-character word waits in the input register while an older result is held;
// its result is then registered and shown on the rsp_ ports.
// Throughput: one character word per cycle unless a final word waits on a held result,
// set by the single parse step between the input register and the state/result registers;
// the result register frees the input side.
// Reset (synchronous, active high) empties both registers and returns the parser to octet 0.
module ipv4_text_address_parser_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_char_code,
   input  logic                           req_last_char,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ipv4p_pkg::ADDR_W-1:0]   rsp_address,
   output logic [ipv4p_pkg::PORT_W-1:0]   rsp_port,
   output logic [ipv4p_pkg::KIND_W-1:0]   rsp_error_kind
);
   import ipv4p_pkg::*;

`include "assert_macros.svh"

   // Input register: holds one character word until the parse step consumes it.
   logic                in_valid_ff;
   logic [CHAR_W-1:0]   in_char_ff;
   logic                in_last_ff;

   // Parser state carried from one character to the next.
   parse_state_type     state_ff;
   parse_state_type     state_in;

   // Result register.
   logic                rsp_valid_ff;
   result_type          rsp_ff;
   result_type          rsp_in;

   logic                out_free;
   logic                step_go;

   // Conditions watched by the checks at the end of the module.
   logic                final_go;
   logic                rsp_quiet;
   logic                payload_clear;
   logic                state_clear;
   logic                acc_in_range;

   // A character that does not end the text never needs the output side, so it
   // advances even while a result waits. The final character needs a free result slot.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_go   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || step_go;

   ipv4p_step u_step (
      .cur       (state_ff),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .nxt       (state_in),
      .res       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step_go) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && in_last_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_address    = rsp_ff.address;
   assign rsp_port       = rsp_ff.port;
   assign rsp_error_kind = rsp_ff.kind;

   assign final_go      = step_go && in_last_ff;
   assign rsp_quiet     = !rsp_valid_ff && !final_go;
   assign payload_clear = !rsp_valid_ff || rsp_ff.kind == ERR_NONE
                        || (rsp_ff.address == '0 && rsp_ff.port == '0);
   assign state_clear   = state_ff.phase == PH_OCT0 && state_ff.octet_acc == '0
                        && state_ff.port_acc == '0 && !state_ff.port_seen;
   assign acc_in_range  = state_ff.octet_acc <= OCTET_SAT && state_ff.port_acc <= PORT_SAT;

   // A failed parse never reports an address or a port.
   `ASSERT_CLK(a_err_clears_payload, clock, reset, payload_clear, "nonzero payload on error")

   // The end of a text puts the parser back to its starting point.
   `ASSERT_NEXT(a_end_resets_state, clock, reset, final_go, state_clear, "state not cleared")

   // Saturating accumulators never pass their ceilings.
   `ASSERT_CLK(a_acc_saturate, clock, reset, acc_in_range, "accumulator past saturation")

   // A result is only produced by a final character.
   `ASSERT_NEXT(a_rsp_source, clock, reset, rsp_quiet, !rsp_valid_ff, "stray result")

endmodule
